>>> rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and character classes
// Scan modes, token kinds, tokenizer state and per-byte label record, plus
// the small character-class functions used by the classifier.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned KindW = 2;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_IDENT  = 3'd1,
		MODE_INT    = 3'd2,
		MODE_STRING = 3'd3,
		MODE_OPER   = 3'd4
	} mode_t;

	typedef enum logic [KindW-1:0] {
		KIND_IDENT  = 2'd0,
		KIND_INT    = 2'd1,
		KIND_STRING = 2'd2,
		KIND_OPER   = 2'd3
	} kind_t;

	localparam logic [ByteW-1:0] ChNul   = 8'h00;
	localparam logic [ByteW-1:0] ChQuote = 8'h22;
	localparam logic [ByteW-1:0] ChUnder = 8'h5F;
	localparam logic [ByteW-1:0] ChEq    = 8'h3D;

	typedef struct packed {
		mode_t            mode;
		logic [ByteW-1:0] first_op;
		kind_t            kind;
	} scan_state_t;

	typedef struct packed {
		logic             is_skipped;
		logic             starts_token;
		kind_t            token_kind;
		logic             end_of_text;
	} label_t;

	localparam scan_state_t ScanReset = '{mode: MODE_IDLE, first_op: '0, kind: KIND_IDENT};

	function automatic logic is_space(input logic [ByteW-1:0] c);
		return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_digit(input logic [ByteW-1:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [ByteW-1:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	// + - * / % & | < > ! =
	function automatic logic in_op_set(input logic [ByteW-1:0] c);
		return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
		       (c == 8'h25) || (c == 8'h26) || (c == 8'h7C) || (c == 8'h3C) ||
		       (c == 8'h3E) || (c == 8'h21) || (c == 8'h3D);
	endfunction

	// + - & | may repeat themselves
	function automatic logic doubles(input logic [ByteW-1:0] c);
		return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h26) || (c == 8'h7C);
	endfunction

endpackage

>>> rtl/tbc_classify.sv
// ----------------------------------------------------------------------------
// tbc_classify: per-byte token labeler
// Labels one byte against the current scan state and forms the next state.
// ----------------------------------------------------------------------------
module tbc_classify (
	input  logic [tbc_pkg::ByteW-1:0] c,
	input  tbc_pkg::scan_state_t      cur,
	output tbc_pkg::label_t           lbl,
	output tbc_pkg::scan_state_t      nxt
);

	logic cont;

	// can this byte extend the open token
	always_comb begin
		unique case (cur.mode)
			tbc_pkg::MODE_IDENT:  cont = tbc_pkg::is_alpha(c) || tbc_pkg::is_digit(c) ||
			                             (c == tbc_pkg::ChUnder);
			tbc_pkg::MODE_INT:    cont = tbc_pkg::is_digit(c);
			tbc_pkg::MODE_STRING: cont = 1'b1;
			tbc_pkg::MODE_OPER:   cont = (c == tbc_pkg::ChEq) ||
			                             (tbc_pkg::doubles(cur.first_op) && (c == cur.first_op));
			default:              cont = 1'b0;
		endcase
	end

	always_comb begin
		nxt = cur;
		lbl = '{is_skipped: 1'b0, starts_token: 1'b0, token_kind: tbc_pkg::KIND_IDENT,
		        end_of_text: 1'b0};
		if (c == tbc_pkg::ChNul) begin
			lbl.end_of_text = 1'b1;
			nxt = tbc_pkg::ScanReset;
		end else if (cont) begin
			lbl.token_kind = cur.kind;
			// close a string on its quote; an operator takes one extra byte only
			if ((cur.mode == tbc_pkg::MODE_STRING && c == tbc_pkg::ChQuote) ||
			    cur.mode == tbc_pkg::MODE_OPER) begin
				nxt.mode = tbc_pkg::MODE_IDLE;
			end
		end else begin
			nxt.mode = tbc_pkg::MODE_IDLE;
			if (tbc_pkg::is_space(c)) begin
				lbl.is_skipped = 1'b1;
			end else begin
				lbl.starts_token = 1'b1;
				if (c == tbc_pkg::ChQuote) begin
					nxt.kind = tbc_pkg::KIND_STRING;
					nxt.mode = tbc_pkg::MODE_STRING;
				end else if (tbc_pkg::is_digit(c)) begin
					nxt.kind = tbc_pkg::KIND_INT;
					nxt.mode = tbc_pkg::MODE_INT;
				end else if (tbc_pkg::is_alpha(c) || c == tbc_pkg::ChUnder) begin
					nxt.kind = tbc_pkg::KIND_IDENT;
					nxt.mode = tbc_pkg::MODE_IDENT;
				end else begin
					nxt.kind = tbc_pkg::KIND_OPER;
					if (tbc_pkg::in_op_set(c)) begin
						nxt.first_op = c;
						nxt.mode = tbc_pkg::MODE_OPER;
					end
				end
				lbl.token_kind = nxt.kind;
			end
		end
	end

endmodule

>>> rtl/c_token_boundary_classifier.sv
// ----------------------------------------------------------------------------
// c_token_boundary_classifier: byte-stream token boundary labeler
// Labels each source byte as skipped whitespace, token start, continuation or end of text.
// ----------------------------------------------------------------------------
// One byte beat in, one label beat out, at a sustained rate of one beat per
// cycle while out_ready holds high. A beat is held in the input register,
// classified against the scan-state register by a short decode, and lands in
// the result register, where out_valid rises; the label is taken at an edge
// with out_ready high. The scan state (mode, first operator byte, current
// kind) advances only when a byte moves into the result register, so stalls
// on either side never disturb the labeling. in_ready stays high while the
// input register is empty or moving, so a new byte is taken while a finished
// label waits for out_ready only if the input register is empty.
// token_kind is 0 for skipped bytes and for the NUL terminator; a NUL raises
// end_of_text and returns the scan state to its reset value, ending any
// unterminated string literal.
module c_token_boundary_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_echo,
	output logic       is_skipped,
	output logic       starts_token,
	output logic [1:0] token_kind,
	output logic       end_of_text
);

	// input stage
	logic                        vld_s1;
	logic [tbc_pkg::ByteW-1:0]   byte_s1;
	// result stage
	logic                        vld_s2;
	logic [tbc_pkg::ByteW-1:0]   byte_s2;
	tbc_pkg::label_t             lbl_s2;
	// scan state
	tbc_pkg::scan_state_t        state_q;

	tbc_pkg::label_t             lbl_d;
	tbc_pkg::scan_state_t        state_d;
	logic                        adv_s2;
	logic                        move_s1;

	// advance the result register when it is empty or being drained
	assign adv_s2   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s2;
	assign move_s1  = vld_s1 && adv_s2;

	tbc_classify u_classify (
		.c   (byte_s1),
		.cur (state_q),
		.lbl (lbl_d),
		.nxt (state_d)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			state_q <= tbc_pkg::ScanReset;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			// commit state only as the byte leaves for the result register
			if (move_s1) begin
				state_q <= state_d;
			end
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
		end
		if (move_s1) begin
			byte_s2 <= byte_s1;
			lbl_s2  <= lbl_d;
		end
	end

	assign out_valid    = vld_s2;
	assign byte_echo    = byte_s2;
	assign is_skipped   = lbl_s2.is_skipped;
	assign starts_token = lbl_s2.starts_token;
	assign token_kind   = lbl_s2.token_kind;
	assign end_of_text  = lbl_s2.end_of_text;

endmodule

>>> rtl/tbc_checker.sv
// ----------------------------------------------------------------------------
// tbc_checker: port-level checks for the token boundary classifier
// Watches the label beats on the result port; bound to the top level.
// ----------------------------------------------------------------------------
module tbc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] byte_echo,
	input  logic       is_skipped,
	input  logic       starts_token,
	input  logic [1:0] token_kind,
	input  logic       end_of_text
);

	// a stalled label beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_echo) &&
		$stable(token_kind) && $stable(starts_token))
		else $error("label beat changed while stalled");

	// end of text exactly on NUL, with no other label
	a_eot_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_of_text == (byte_echo == tbc_pkg::ChNul)))
		else $error("end_of_text does not match NUL byte");

	a_eot_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_text |-> !is_skipped && !starts_token &&
		token_kind == tbc_pkg::KIND_IDENT)
		else $error("NUL beat carries a token label");

	// skipped bytes are whitespace and start nothing
	a_skip_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_skipped |-> !starts_token && token_kind == tbc_pkg::KIND_IDENT &&
		(byte_echo == 8'h20 || (byte_echo >= 8'h09 && byte_echo <= 8'h0D)))
		else $error("skipped beat is not plain whitespace");

endmodule

bind c_token_boundary_classifier tbc_checker u_tbc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.byte_echo    (byte_echo),
	.is_skipped   (is_skipped),
	.starts_token (starts_token),
	.token_kind   (token_kind),
	.end_of_text  (end_of_text)
);
